>>> hdl/etsm_pkg.sv
// shared types, constants and rounding helpers for the euler translate-scale matrix unit
// no dependencies; compiled first
package etsm_pkg;

	localparam int WORD_W      = 32;
	localparam int ANGLE_W     = 16;
	localparam int SINE_W      = 16;
	localparam int SINE_MAG_W  = 15;
	localparam int SINE_SHIFT  = 14;
	localparam int ROW_W       = 2;
	localparam int AXES        = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCOUNT_W    = 3;

	localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
	localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

	typedef logic signed [WORD_W-1:0]  word_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [SINE_W-1:0]  sine_t;

	// one finished matrix before scaling, as handed from front to back
	typedef struct packed {
		word_t [2:0][2:0] m;
		word_t [2:0]      trans;
		word_t [2:0]      scale;
		logic             unit;
	} item_t;

	// round half away from zero, then drop s fraction bits
	function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] half;
		logic signed [63:0] adj;
		half = 64'sd1 <<< (s - 1);
		adj  = v[63] ? half - 64'sd1 : half;
		return (v + adj) >>> s;
	endfunction

	function automatic word_t sat_word(input logic signed [63:0] v);
		word_t res;
		if (v > 64'sd2147483647) begin
			res = {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v < -64'sd2147483648) begin
			res = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			res = v[WORD_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> hdl/etsm_channels.sv
// valid/ready channel interfaces for input transforms and output matrix rows
// depends on etsm_pkg
interface etsm_in_if;
	import etsm_pkg::*;

	logic   valid;
	logic   ready;
	angle_t rot_x;
	angle_t rot_y;
	angle_t rot_z;
	word_t  trans_x;
	word_t  trans_y;
	word_t  trans_z;
	word_t  scale_x;
	word_t  scale_y;
	word_t  scale_z;

	modport source(output valid, rot_x, rot_y, rot_z, trans_x, trans_y, trans_z,
		scale_x, scale_y, scale_z, input ready);
	modport sink(input valid, rot_x, rot_y, rot_z, trans_x, trans_y, trans_z,
		scale_x, scale_y, scale_z, output ready);
endinterface

interface etsm_out_if;
	import etsm_pkg::*;

	logic             valid;
	logic             ready;
	word_t            entry_c0;
	word_t            entry_c1;
	word_t            entry_c2;
	word_t            entry_c3;
	logic [ROW_W-1:0] row_index;
	logic             last_row;
	logic             scale_one;

	modport source(output valid, entry_c0, entry_c1, entry_c2, entry_c3, row_index,
		last_row, scale_one, input ready);
	modport sink(input valid, entry_c0, entry_c1, entry_c2, entry_c3, row_index,
		last_row, scale_one, output ready);
endinterface

>>> hdl/etsm_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module etsm_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> hdl/etsm_front.sv
// front end: accepts transforms, fills and reads the quarter-wave sine ram, builds the
// rotate-translate matrix and flags unit scale; uses etsm_pkg, etsm_channels, etsm_ram
module etsm_front #(
	parameter int SINE_TABLE_BITS = 12,
	parameter int FRACTION_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	etsm_in_if.sink         in_ch,
	output logic            push,
	output etsm_pkg::item_t push_data,
	input  logic            pop
);
	import etsm_pkg::*;

	localparam int QTR_SIZE     = 2 ** (SINE_TABLE_BITS - 2);
	localparam int QTR_HALF     = QTR_SIZE / 2;
	localparam int ROM_DEPTH    = QTR_SIZE + 1;
	localparam int ADDR_W       = SINE_TABLE_BITS - 1;
	localparam int PROD_W       = 30;
	localparam int CROSS_W      = 45;
	localparam int PAIR_SHIFT   = 2 * SINE_SHIFT - FRACTION_BITS;
	localparam int TRIPLE_SHIFT = 3 * SINE_SHIFT - FRACTION_BITS;
	localparam int M20_UP       = (FRACTION_BITS >= SINE_SHIFT) ? FRACTION_BITS - SINE_SHIFT : 0;
	localparam int M20_DN       = (FRACTION_BITS < SINE_SHIFT) ? SINE_SHIFT - FRACTION_BITS : 0;
	localparam int TAYLOR_TERMS = 10;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam word_t SCALE_ONE    = word_t'(64'sd1 <<< FRACTION_BITS);

	typedef logic [SINE_MAG_W-1:0] rom_t [ROM_DEPTH];
	typedef logic signed [PROD_W-1:0]  pair_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

	typedef struct packed {
		word_t [2:0] trans;
		word_t [2:0] scale;
		logic        unit;
	} side_t;

	// quotient truncated toward zero, long division on magnitudes; table build only
	function automatic longint div_trunc(input longint num, input longint den);
		logic [63:0] n_mag;
		logic [63:0] d_mag;
		logic [63:0] quo;
		logic [63:0] rem;
		int          b;
		n_mag = (num < 0) ? 64'(-num) : 64'(num);
		d_mag = 64'(den);
		quo   = '0;
		rem   = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n_mag[b]};
			quo = {quo[62:0], 1'b0};
			if (rem >= d_mag) begin
				rem    = rem - d_mag;
				quo[0] = 1'b1;
			end
		end
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// first quarter of a sine wave in q1.14, taylor series in q30
	function automatic rom_t build_rom();
		rom_t   tbl;
		longint x;
		longint term;
		longint acc;
		longint v;
		int     i;
		int     k;
		for (i = 0; i < ROM_DEPTH; i++) begin
			x = (HALF_PI_Q30 * longint'(i) + longint'(QTR_HALF)) >>> (SINE_TABLE_BITS - 2);
			term = x;
			acc  = x;
			for (k = 1; k <= TAYLOR_TERMS; k++) begin
				term = div_trunc(term * x, ONE_Q30);
				term = div_trunc(term * x, ONE_Q30);
				term = div_trunc(-term, longint'((2 * k) * (2 * k + 1)));
				acc  = acc + term;
			end
			if (acc < 0) acc = 0;
			v = (acc + 64'sd32768) >>> 16;
			if (v > 16384) v = 16384;
			tbl[i] = v[SINE_MAG_W-1:0];
		end
		return tbl;
	endfunction

	localparam rom_t QUARTER_ROM = build_rom();

	// ram fill after reset
	logic              fill_done_q;
	logic [ADDR_W-1:0] fill_addr_q;

	// holding register and axis sequencer
	logic                  busy_q;
	axis_t                 axis_q;
	angle_t                rot_q   [AXES];
	word_t                 trans_q [AXES];
	word_t                 scale_q [AXES];
	logic [QCOUNT_W-1:0]   credit_q;
	logic                  accept;
	logic                  last_issue;

	angle_t                    angle;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                quad_s;
	logic [1:0]                quad_c;
	logic [SINE_TABLE_BITS-3:0] frac;
	logic [ADDR_W-1:0]         addr_s;
	logic [ADDR_W-1:0]         addr_c;
	logic [SINE_MAG_W-1:0]     rd_s;
	logic [SINE_MAG_W-1:0]     rd_c;

	// stage 1: ram read
	logic  v_s1;
	axis_t axis_s1;
	logic  neg_s_s1;
	logic  neg_c_s1;
	side_t side_s1;
	sine_t sin_val;
	sine_t cos_val;
	sine_t sin_q [2];
	sine_t cos_q [2];

	// stage 2: all six sine/cosine values
	logic  v_s2;
	sine_t sin_s2 [AXES];
	sine_t cos_s2 [AXES];
	side_t side_s2;

	// stage 3: pair products
	logic  v_s3;
	pair_t p_c2c1_s3, p_s2c1_s3, p_c1s0_s3, p_c1c0_s3;
	pair_t p_s0c2_s3, p_c0s2_s3, p_c0c2_s3, p_s0s2_s3;
	sine_t sy_s3;
	word_t m20_s3;
	side_t side_s3;
	sine_t neg_sy;
	word_t m20;

	// stage 4: triple products, pair entries rounded
	logic             v_s4;
	word_t [2:0][2:0] m_s4;
	cross_t           a_s4, b_s4, c_s4, d_s4;
	pair_t            p_s0c2_s4, p_c0s2_s4, p_c0c2_s4, p_s0s2_s4;
	side_t            side_s4;

	// stage 5: cross sums
	logic             v_s5;
	word_t [2:0][2:0] m_s5;
	cross_t           x01_s5, x12_s5, x02_s5, x11_s5;
	side_t            side_s5;

	// stage 6: finished item
	logic  v_s6;
	item_t item_s6;

	etsm_ram #(
		.WIDTH(SINE_MAG_W),
		.DEPTH(ROM_DEPTH)
	) u_sine_ram (
		.clk    (clk),
		.we     (!fill_done_q),
		.waddr  (fill_addr_q),
		.wdata  (QUARTER_ROM[fill_addr_q]),
		.raddr_a(addr_s),
		.raddr_b(addr_c),
		.rdata_a(rd_s),
		.rdata_b(rd_c)
	);

	// a new word may enter while the last axis of the previous one is read
	assign in_ch.ready = fill_done_q && (credit_q != '0) && (!busy_q || axis_q == AXIS_Z);
	assign accept      = in_ch.valid && in_ch.ready;
	assign last_issue  = busy_q && (axis_q == AXIS_Z);

	always_comb begin
		case (axis_q)
			AXIS_X:  angle = rot_q[0];
			AXIS_Y:  angle = rot_q[1];
			default: angle = rot_q[2];
		endcase
		idx    = angle[ANGLE_W-1 -: SINE_TABLE_BITS];
		quad_s = idx[SINE_TABLE_BITS-1 -: 2];
		frac   = idx[SINE_TABLE_BITS-3:0];
		quad_c = quad_s + 2'd1;
		addr_s = quad_s[0] ? ADDR_W'(QTR_SIZE) - {1'b0, frac} : {1'b0, frac};
		addr_c = quad_c[0] ? ADDR_W'(QTR_SIZE) - {1'b0, frac} : {1'b0, frac};
	end

	always_comb begin
		sin_val = neg_s_s1 ? -sine_t'({1'b0, rd_s}) : sine_t'({1'b0, rd_s});
		cos_val = neg_c_s1 ? -sine_t'({1'b0, rd_c}) : sine_t'({1'b0, rd_c});
	end

	// -sin(y) taken from q1.14 to the output fraction
	always_comb begin
		neg_sy = -sin_s2[1];
		if (FRACTION_BITS >= SINE_SHIFT) begin
			m20 = word_t'(neg_sy) <<< M20_UP;
		end else begin
			m20 = word_t'(round_shr(64'(neg_sy), M20_DN));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_done_q <= 1'b0;
			fill_addr_q <= '0;
			busy_q      <= 1'b0;
			axis_q      <= AXIS_X;
			credit_q    <= QCOUNT_W'(QUEUE_DEPTH);
			v_s1        <= 1'b0;
			axis_s1     <= AXIS_X;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
		end else begin
			if (!fill_done_q) begin
				fill_addr_q <= fill_addr_q + 1'b1;
				if (fill_addr_q == ADDR_W'(QTR_SIZE)) begin
					fill_done_q <= 1'b1;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
				axis_q <= AXIS_X;
			end else if (busy_q) begin
				case (axis_q)
					AXIS_X:  axis_q <= AXIS_Y;
					AXIS_Y:  axis_q <= AXIS_Z;
					default: busy_q <= 1'b0;
				endcase
			end
			if (accept && !pop) begin
				credit_q <= credit_q - 1'b1;
			end else if (!accept && pop) begin
				credit_q <= credit_q + 1'b1;
			end
			v_s1    <= busy_q;
			axis_s1 <= axis_q;
			v_s2    <= v_s1 && (axis_s1 == AXIS_Z);
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rot_q[0]   <= in_ch.rot_x;
			rot_q[1]   <= in_ch.rot_y;
			rot_q[2]   <= in_ch.rot_z;
			trans_q[0] <= in_ch.trans_x;
			trans_q[1] <= in_ch.trans_y;
			trans_q[2] <= in_ch.trans_z;
			scale_q[0] <= in_ch.scale_x;
			scale_q[1] <= in_ch.scale_y;
			scale_q[2] <= in_ch.scale_z;
		end

		neg_s_s1 <= quad_s[1];
		neg_c_s1 <= quad_c[1];
		if (last_issue) begin
			side_s1.trans <= {trans_q[2], trans_q[1], trans_q[0]};
			side_s1.scale <= {scale_q[2], scale_q[1], scale_q[0]};
			side_s1.unit  <= (scale_q[0] == SCALE_ONE) && (scale_q[1] == SCALE_ONE)
				&& (scale_q[2] == SCALE_ONE);
		end

		if (v_s1) begin
			case (axis_s1)
				AXIS_X: begin
					sin_q[0] <= sin_val;
					cos_q[0] <= cos_val;
				end
				AXIS_Y: begin
					sin_q[1] <= sin_val;
					cos_q[1] <= cos_val;
				end
				default: begin
					sin_s2[0] <= sin_q[0];
					sin_s2[1] <= sin_q[1];
					sin_s2[2] <= sin_val;
					cos_s2[0] <= cos_q[0];
					cos_s2[1] <= cos_q[1];
					cos_s2[2] <= cos_val;
					side_s2   <= side_s1;
				end
			endcase
		end

		p_c2c1_s3 <= pair_t'(cos_s2[2]) * pair_t'(cos_s2[1]);
		p_s2c1_s3 <= pair_t'(sin_s2[2]) * pair_t'(cos_s2[1]);
		p_c1s0_s3 <= pair_t'(cos_s2[1]) * pair_t'(sin_s2[0]);
		p_c1c0_s3 <= pair_t'(cos_s2[1]) * pair_t'(cos_s2[0]);
		p_s0c2_s3 <= pair_t'(sin_s2[0]) * pair_t'(cos_s2[2]);
		p_c0s2_s3 <= pair_t'(cos_s2[0]) * pair_t'(sin_s2[2]);
		p_c0c2_s3 <= pair_t'(cos_s2[0]) * pair_t'(cos_s2[2]);
		p_s0s2_s3 <= pair_t'(sin_s2[0]) * pair_t'(sin_s2[2]);
		sy_s3     <= sin_s2[1];
		m20_s3    <= m20;
		side_s3   <= side_s2;

		// cross entries are filled from the cross sums when the finished item is built
		m_s4[0][1] <= '0;
		m_s4[0][2] <= '0;
		m_s4[1][1] <= '0;
		m_s4[1][2] <= '0;
		m_s4[0][0] <= word_t'(round_shr(64'(p_c2c1_s3), PAIR_SHIFT));
		m_s4[1][0] <= word_t'(round_shr(64'(p_s2c1_s3), PAIR_SHIFT));
		m_s4[2][1] <= word_t'(round_shr(64'(p_c1s0_s3), PAIR_SHIFT));
		m_s4[2][2] <= word_t'(round_shr(64'(p_c1c0_s3), PAIR_SHIFT));
		m_s4[2][0] <= m20_s3;
		a_s4       <= cross_t'(p_s0c2_s3) * cross_t'(sy_s3);
		b_s4       <= cross_t'(p_c0s2_s3) * cross_t'(sy_s3);
		c_s4       <= cross_t'(p_c0c2_s3) * cross_t'(sy_s3);
		d_s4       <= cross_t'(p_s0s2_s3) * cross_t'(sy_s3);
		p_s0c2_s4  <= p_s0c2_s3;
		p_c0s2_s4  <= p_c0s2_s3;
		p_c0c2_s4  <= p_c0c2_s3;
		p_s0s2_s4  <= p_s0s2_s3;
		side_s4    <= side_s3;

		// q42 cross terms: three-factor product against a q28 pair scaled by one
		x01_s5  <= a_s4 - (CROSS_W'(p_c0s2_s4) <<< SINE_SHIFT);
		x12_s5  <= b_s4 - (CROSS_W'(p_s0c2_s4) <<< SINE_SHIFT);
		x02_s5  <= c_s4 + (CROSS_W'(p_s0s2_s4) <<< SINE_SHIFT);
		x11_s5  <= d_s4 + (CROSS_W'(p_c0c2_s4) <<< SINE_SHIFT);
		m_s5    <= m_s4;
		side_s5 <= side_s4;

		item_s6.m[0][0] <= m_s5[0][0];
		item_s6.m[1][0] <= m_s5[1][0];
		item_s6.m[2][0] <= m_s5[2][0];
		item_s6.m[2][1] <= m_s5[2][1];
		item_s6.m[2][2] <= m_s5[2][2];
		item_s6.m[0][1] <= word_t'(round_shr(64'(x01_s5), TRIPLE_SHIFT));
		item_s6.m[1][2] <= word_t'(round_shr(64'(x12_s5), TRIPLE_SHIFT));
		item_s6.m[0][2] <= word_t'(round_shr(64'(x02_s5), TRIPLE_SHIFT));
		item_s6.m[1][1] <= word_t'(round_shr(64'(x11_s5), TRIPLE_SHIFT));
		item_s6.trans   <= side_s5.trans;
		item_s6.scale   <= side_s5.scale;
		item_s6.unit    <= side_s5.unit;
	end

	assign push      = v_s6;
	assign push_data = item_s6;

endmodule

>>> hdl/etsm_queue.sv
// short fifo of finished matrices between front and back
// depends on etsm_pkg; the front never pushes into a full queue
module etsm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  etsm_pkg::item_t push_data,
	input  logic            pop,
	output logic            head_valid,
	output etsm_pkg::item_t head
);
	import etsm_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

endmodule

>>> hdl/etsm_back.sv
// back end: walks the three rows of the queue head, applies per-column scale
// with rounding and saturation, drives out_ch; depends on etsm_pkg, etsm_channels
module etsm_back #(
	parameter int FRACTION_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  etsm_pkg::item_t head,
	input  logic            head_valid,
	output logic            pop,
	etsm_out_if.source      out_ch
);
	import etsm_pkg::*;

	logic             adv;
	logic             issue;
	logic [ROW_W-1:0] row_q;

	logic               v_s1;
	logic signed [63:0] prod_s1 [AXES];
	word_t              raw_s1  [AXES];
	word_t              trans_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               unit_s1;

	logic             out_valid_q;
	word_t            entry_q [AXES];
	word_t            trans_q;
	logic [ROW_W-1:0] out_row_q;
	logic             last_q;
	logic             unit_q;

	// the whole row pipe moves whenever the output register can take a word
	assign adv   = !out_valid_q || out_ch.ready;
	assign issue = adv && head_valid;
	assign pop   = issue && (row_q == ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= ROW_FIRST;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				row_q <= (row_q == ROW_LAST) ? ROW_FIRST : row_q + 1'b1;
			end
			if (adv) begin
				v_s1        <= issue;
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < AXES; c++) begin
				prod_s1[c] <= 64'($signed(head.m[row_q][c])) * 64'($signed(head.scale[c]));
				raw_s1[c]  <= head.m[row_q][c];
			end
			trans_s1 <= head.trans[row_q];
			row_s1   <= row_q;
			unit_s1  <= head.unit;

			for (int c = 0; c < AXES; c++) begin
				entry_q[c] <= unit_s1 ? raw_s1[c]
					: sat_word(round_shr(prod_s1[c], FRACTION_BITS));
			end
			trans_q   <= trans_s1;
			out_row_q <= row_s1;
			last_q    <= (row_s1 == ROW_LAST);
			unit_q    <= unit_s1;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.entry_c0  = entry_q[0];
	assign out_ch.entry_c1  = entry_q[1];
	assign out_ch.entry_c2  = entry_q[2];
	assign out_ch.entry_c3  = trans_q;
	assign out_ch.row_index = out_row_q;
	assign out_ch.last_row  = last_q;
	assign out_ch.scale_one = unit_q;

endmodule

>>> hdl/euler_translate_scale_matrix_unit.sv
// euler xyz rotate-translate matrix with per-axis scale, three row words per transform
// throughput: one row word per cycle on the output while out_ch is ready; the front
// can take a new transform as the last axis of the previous one is read, the sine ram's
// two read ports serving sine and cosine of one axis a cycle. reset: a fill sweep loads
// all 2^(SINE_TABLE_BITS-2)+1 entries (1025 by default) of the sine ram; in_ch.ready
// stays low until it is done. depends on etsm_pkg and all etsm_* files
module euler_translate_scale_matrix_unit #(
	parameter int SINE_TABLE_BITS = 12,  // 8 to 14
	parameter int FRACTION_BITS   = 16   // 8 to 24
) (
	input  logic       clk,
	input  logic       arst_n,
	etsm_in_if.sink    in_ch,
	etsm_out_if.source out_ch
);
	import etsm_pkg::*;

	// front to queue
	logic  push;
	item_t push_data;

	// queue to back
	logic  pop;
	logic  head_valid;
	item_t head;

	// front: accept, sine/cosine lookup one axis a cycle, matrix products in a
	// six-stage pipe that never stalls; it takes a word only while it holds a
	// free queue slot as credit, so the pipe can always drain into the queue
	etsm_front #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.push     (push),
		.push_data(push_data),
		.pop      (pop)
	);

	// decoupling queue: lets the front keep working while the output stalls
	etsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// back: one row per cycle while out_ch is ready, scale multiply then round/saturate
	// into the output register; the head leaves the queue as its last row is issued
	etsm_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

>>> tb/tb.sv
// testbench for euler_translate_scale_matrix_unit: directed table, then random transforms
// checked word by word against a local fixed-point predictor of the three matrix rows
// depends on etsm_pkg, etsm_channels and the unit itself
module tb;
	import etsm_pkg::*;

	localparam int TABLE_BITS  = 12;
	localparam int FRAC        = 16;
	localparam int QUARTER     = (1 << TABLE_BITS) / 4;
	localparam int ANGLE_SHIFT = ANGLE_W - TABLE_BITS;
	localparam int LONG_HOLD   = 120;
	localparam int SETTLE      = 30;
	localparam int CHUNKS      = 8;
	localparam int CHUNK_ITEMS = 40;
	localparam int LIMIT       = 200000;
	localparam int PRINT_CAP   = 40;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint WORD_MAX    = 64'sd2147483647;
	localparam longint WORD_MIN    = -64'sd2147483648;
	localparam word_t  UNIT        = 32'sh0001_0000;

	typedef struct {
		angle_t rot[3];
		word_t  trans[3];
		word_t  scale[3];
	} xform_t;

	typedef struct {
		word_t            entry_c0;
		word_t            entry_c1;
		word_t            entry_c2;
		word_t            entry_c3;
		logic [ROW_W-1:0] row_index;
		logic             last_row;
		logic             scale_one;
	} matrix_row_t;

	// typed_exp rows carry a diagonal result readable at a glance (zero angles)
	typedef struct {
		angle_t rx, ry, rz;
		word_t  tx, ty, tz;
		word_t  sx, sy, sz;
		bit     typed_exp;
		word_t  d0, d1, d2;
		bit     one;
	} stim_row_t;

	stim_row_t directed_rows [20] = '{
		// zero angles, unit scale, translation extremes
		'{16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			UNIT, UNIT, UNIT, 1'b1, UNIT, UNIT, UNIT, 1'b1},
		'{16'h0000, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			UNIT, UNIT, UNIT, 1'b1, UNIT, UNIT, UNIT, 1'b1},
		// zero scale
		'{16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
			32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
		// scale extremes and minus one
		'{16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0},
		// one axis just off unit, or all axes off unit, so scaling is applied
		'{16'h0000, 16'h0000, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
			32'h0001_0001, UNIT, UNIT, 1'b1, 32'h0001_0001, UNIT, UNIT, 1'b0},
		'{16'h0000, 16'h0000, 16'h0000, 32'hF0F0_F0F0, 32'h0000_0001, 32'h8000_0001,
			UNIT, UNIT, 32'h0000_FFFF, 1'b1, UNIT, UNIT, 32'h0000_FFFF, 1'b0},
		'{16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0,
			32'h0002_0000, 32'h0000_8000, 32'h0000_0001, 1'b1,
			32'h0002_0000, 32'h0000_8000, 32'h0000_0001, 1'b0},
		// quarter turns on each axis
		'{16'h4000, 16'h0000, 16'h0000, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h0000, 16'h4000, 16'h0000, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h0000, 16'h0000, 16'h4000, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		// angle extremes
		'{16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		// mixed angles with ordinary and negative scales
		'{16'hC000, 16'h2000, 16'hE000, 32'h0, 32'h0, 32'h0,
			32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		// large scales, where products may saturate
		'{16'h1234, 16'h5678, 16'h9ABC, 32'h0, 32'h0, 32'h0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h1234, 16'h5678, 16'h9ABC, 32'h0, 32'h0, 32'h0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h2000, 16'h2000, 16'h2000, 32'h0, 32'h0, 32'h0,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		// low angle bits dropped by the table index
		'{16'h000F, 16'h0010, 16'hFFF0, 32'h0, 32'h0, 32'h0,
			UNIT, UNIT, UNIT, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h6000, 16'hA000, 16'h3000, 32'h0, 32'h0, 32'h0,
			32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{16'h4000, 16'h4000, 16'h4000, 32'h0, 32'h0, 32'h0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	etsm_in_if  in_ch();
	etsm_out_if out_ch();

	euler_translate_scale_matrix_unit #(
		.SINE_TABLE_BITS(TABLE_BITS),
		.FRACTION_BITS  (FRAC)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	longint      sine_quarter [0:QUARTER];
	matrix_row_t rows_due [$];
	matrix_row_t due;
	int          error_count = 0;
	int          cycle_count = 0;
	int          in_idle_pct = 0;
	int          out_idle_pct = 0;
	bit          hold_req = 1'b0;

	function automatic longint sine_lookup(int unsigned idx);
		int unsigned quad;
		int unsigned r;
		quad = (idx / QUARTER) & 3;
		r = idx % QUARTER;
		case (quad)
			0: return sine_quarter[r];
			1: return sine_quarter[QUARTER - r];
			2: return -sine_quarter[r];
			default: return -sine_quarter[QUARTER - r];
		endcase
	endfunction

	// round half away from zero, drop s fraction bits
	function automatic longint round_away(longint v, int s);
		longint mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -mag : mag;
	endfunction

	function automatic longint to_q16(longint v, int qin);
		if (qin > FRAC)
			return round_away(v, qin - FRAC);
		return v * (64'sd1 <<< (FRAC - qin));
	endfunction

	// build the three rows of Rz*Ry*Rx with translation, scaled per column
	function automatic void push_matrix_rows(xform_t x);
		longint      s[3];
		longint      c[3];
		longint      m[3][3];
		longint      p;
		int unsigned idx;
		bit          unit;
		matrix_row_t e;
		for (int a = 0; a < 3; a++) begin
			idx = {16'h0000, x.rot[a]} >> ANGLE_SHIFT;
			s[a] = sine_lookup(idx);
			c[a] = sine_lookup((idx + QUARTER) & (4 * QUARTER - 1));
		end
		m[0][0] = to_q16(c[2] * c[1], 28);
		m[1][0] = to_q16(s[2] * c[1], 28);
		m[2][0] = to_q16(-s[1], 14);
		m[2][1] = to_q16(c[1] * s[0], 28);
		m[2][2] = to_q16(c[1] * c[0], 28);
		m[0][1] = to_q16(s[0] * c[2] * s[1] - c[0] * s[2] * 16384, 42);
		m[1][2] = to_q16(c[0] * s[2] * s[1] - s[0] * c[2] * 16384, 42);
		m[0][2] = to_q16(c[0] * c[2] * s[1] + s[0] * s[2] * 16384, 42);
		m[1][1] = to_q16(s[0] * s[2] * s[1] + c[0] * c[2] * 16384, 42);
		unit = x.scale[0] == UNIT && x.scale[1] == UNIT && x.scale[2] == UNIT;
		if (!unit) begin
			for (int r = 0; r < 3; r++) begin
				for (int col = 0; col < 3; col++) begin
					p = round_away(m[r][col] * longint'(x.scale[col]), FRAC);
					if (p > WORD_MAX)
						p = WORD_MAX;
					else if (p < WORD_MIN)
						p = WORD_MIN;
					m[r][col] = p;
				end
			end
		end
		for (int r = 0; r < 3; r++) begin
			e.entry_c0 = word_t'(m[r][0]);
			e.entry_c1 = word_t'(m[r][1]);
			e.entry_c2 = word_t'(m[r][2]);
			e.entry_c3 = x.trans[r];
			e.row_index = ROW_W'(r);
			e.last_row = ROW_W'(r) == ROW_LAST;
			e.scale_one = unit;
			rows_due.push_back(e);
		end
	endfunction

	// returns at the edge where the word is taken
	task automatic offer_xform(input xform_t x);
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rot_x   <= x.rot[0];
		in_ch.rot_y   <= x.rot[1];
		in_ch.rot_z   <= x.rot[2];
		in_ch.trans_x <= x.trans[0];
		in_ch.trans_y <= x.trans[1];
		in_ch.trans_z <= x.trans[2];
		in_ch.scale_x <= x.scale[0];
		in_ch.scale_y <= x.scale[1];
		in_ch.scale_z <= x.scale[2];
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	// receiver: short random stalls, plus one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each taken row word with the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (rows_due.size() == 0) begin
				report_mismatch($sformatf("row word %0d with nothing due", out_ch.row_index));
			end else begin
				due = rows_due.pop_front();
				if (out_ch.entry_c0 !== due.entry_c0)
					report_mismatch($sformatf("row %0d entry_c0 got %0d want %0d",
						due.row_index, out_ch.entry_c0, due.entry_c0));
				if (out_ch.entry_c1 !== due.entry_c1)
					report_mismatch($sformatf("row %0d entry_c1 got %0d want %0d",
						due.row_index, out_ch.entry_c1, due.entry_c1));
				if (out_ch.entry_c2 !== due.entry_c2)
					report_mismatch($sformatf("row %0d entry_c2 got %0d want %0d",
						due.row_index, out_ch.entry_c2, due.entry_c2));
				if (out_ch.entry_c3 !== due.entry_c3)
					report_mismatch($sformatf("row %0d entry_c3 got %0d want %0d",
						due.row_index, out_ch.entry_c3, due.entry_c3));
				if (out_ch.row_index !== due.row_index)
					report_mismatch($sformatf("row_index got %0d want %0d",
						out_ch.row_index, due.row_index));
				if (out_ch.last_row !== due.last_row)
					report_mismatch($sformatf("row %0d last_row got %b want %b",
						due.row_index, out_ch.last_row, due.last_row));
				if (out_ch.scale_one !== due.scale_one)
					report_mismatch($sformatf("row %0d scale_one got %b want %b",
						due.row_index, out_ch.scale_one, due.scale_one));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("FAIL euler_translate_scale_matrix_unit");
			$finish;
		end
	end

	initial begin
		xform_t      item;
		stim_row_t   row;
		matrix_row_t e;
		word_t       diag[3];
		int          pick;
		longint      ang, term, total, rv;

		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.rot_x   <= '0;
		in_ch.rot_y   <= '0;
		in_ch.rot_z   <= '0;
		in_ch.trans_x <= '0;
		in_ch.trans_y <= '0;
		in_ch.trans_z <= '0;
		in_ch.scale_x <= '0;
		in_ch.scale_y <= '0;
		in_ch.scale_z <= '0;

		// quarter sine table: taylor series in q30, rounded to q14
		for (int i = 0; i <= QUARTER; i++) begin
			ang = (HALF_PI_Q30 * i + QUARTER / 2) / QUARTER;
			term = ang;
			total = ang;
			for (int k = 1; k <= 10; k++) begin
				term = term * ang / ONE_Q30;
				term = term * ang / ONE_Q30;
				term = -term / ((2 * k) * (2 * k + 1));
				total += term;
			end
			if (total < 0)
				total = 0;
			rv = (total + 32768) >>> 16;
			if (rv > 16384)
				rv = 16384;
			sine_quarter[i] = rv;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		in_idle_pct = 20;
		out_idle_pct = 20;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			item.rot   = '{row.rx, row.ry, row.rz};
			item.trans = '{row.tx, row.ty, row.tz};
			item.scale = '{row.sx, row.sy, row.sz};
			offer_xform(item);
			if (row.typed_exp) begin
				diag = '{row.d0, row.d1, row.d2};
				for (int r = 0; r < 3; r++) begin
					e.entry_c0 = r == 0 ? diag[0] : '0;
					e.entry_c1 = r == 1 ? diag[1] : '0;
					e.entry_c2 = r == 2 ? diag[2] : '0;
					e.entry_c3 = item.trans[r];
					e.row_index = ROW_W'(r);
					e.last_row = ROW_W'(r) == ROW_LAST;
					e.scale_one = row.one;
					rows_due.push_back(e);
				end
			end else begin
				push_matrix_rows(item);
			end
		end

		// random part in chunks, each with its own idle mix
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			if (chunk == CHUNKS - 1) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else if (chunk == 2) begin
				// sender keeps pushing while the receiver holds off
				in_idle_pct = 0;
				out_idle_pct = 10;
				hold_req = 1'b1;
			end else begin
				in_idle_pct = $urandom_range(0, 2) * 20;
				out_idle_pct = $urandom_range(0, 2) * 20;
			end
			if (chunk == 4) begin
				// sender pauses until the unit has drained
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (rows_due.size() != 0);
			end
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				for (int a = 0; a < 3; a++) begin
					if ($urandom_range(0, 4) == 0)
						item.rot[a] = angle_t'({2'($urandom_range(0, 3)),
							14'($urandom_range(0, 15))});
					else
						item.rot[a] = angle_t'($urandom);
					item.trans[a] = word_t'($urandom);
					item.scale[a] = UNIT;
				end
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					// unit scale, no multiply
				end else if (pick < 5) begin
					for (int a = 0; a < 3; a++)
						item.scale[a] = word_t'($urandom_range(0, 32'h0010_0000))
							- 32'sh0008_0000;
				end else if (pick == 5) begin
					item.scale[$urandom_range(0, 2)] = $urandom_range(0, 1) ? UNIT + 1 : UNIT - 1;
				end else if (pick < 9) begin
					for (int a = 0; a < 3; a++)
						item.scale[a] = word_t'($urandom);
				end else begin
					for (int a = 0; a < 3; a++) begin
						case ($urandom_range(0, 3))
							0: item.scale[a] = 32'sh7FFF_FFFF;
							1: item.scale[a] = 32'sh8000_0000;
							2: item.scale[a] = '0;
							default: item.scale[a] = -UNIT;
						endcase
					end
				end
				offer_xform(item);
				push_matrix_rows(item);
			end
		end

		in_ch.valid <= 1'b0;
		do @(posedge clk); while (rows_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("PASS euler_translate_scale_matrix_unit");
		else
			$display("FAIL euler_translate_scale_matrix_unit");
		$finish;
	end

endmodule

>>> sim.f
hdl/etsm_pkg.sv
hdl/etsm_channels.sv
hdl/etsm_ram.sv
hdl/etsm_front.sv
hdl/etsm_queue.sv
hdl/etsm_back.sv
hdl/euler_translate_scale_matrix_unit.sv
tb/tb.sv
